@@ sv/pccm_pkg.sv @@
package pccm_pkg;

    // default geometry of the watched window
    localparam int WINDOW_PAGES_DEF     = 65536;
    localparam int SAMPLES_PER_PAGE_DEF = 512;

    // fixed field widths
    localparam int PAGE_W      = 20;
    localparam int IDX_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int POP_W       = 10;
    localparam int TICK_W      = 17;
    localparam int DROP_W      = 7;
    localparam int HASH_W      = 64;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 20;

    // 64-bit fnv-1a offset basis
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam int PERCENT_SCALE = 100;
    localparam int FULL_PERCENT  = 90;

    localparam logic [DROP_W-1:0] PCT_MAX = DROP_W'(PERCENT_SCALE);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam logic [DROP_W-1:0] DROP_PERCENT_RST = 7'd25;
    localparam logic [PAGE_W-1:0] WINDOW_BASE_RST  = 20'd57344;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_PERCENT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BASE  = 1'd1;

    // result kinds
    localparam logic RK_PAGE = 1'b0;
    localparam logic RK_TICK = 1'b1;

    typedef enum logic [1:0] {
        REQ_SAMPLE   = 2'd0,
        REQ_UNMAPPED = 2'd1,
        REQ_TICK     = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        EV_BASELINE   = 3'd0,
        EV_UNCHANGED  = 3'd1,
        EV_DEGRADED   = 3'd2,
        EV_REPLACED   = 3'd3,
        EV_FILLED     = 3'd4,
        EV_MINOR_DROP = 3'd5
    } page_event_t;

    typedef enum logic [1:0] {
        CLS_EMPTY   = 2'd0,
        CLS_PARTIAL = 2'd1,
        CLS_FULL    = 2'd2
    } page_class_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [IDX_W-1:0]  page_index;
        logic [BYTE_W-1:0] sample_byte;
        logic              last_sample;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [PAGE_W-1:0] page_number;
        logic [2:0]        page_event;
        logic [1:0]        page_class;
        logic [POP_W-1:0]  populated_samples;
        logic [TICK_W-1:0] full_pages;
        logic [TICK_W-1:0] partial_pages;
        logic [TICK_W-1:0] empty_pages;
        logic [TICK_W-1:0] unmapped_pages;
        logic [PAGE_W-1:0] first_populated;
        logic [PAGE_W-1:0] last_populated;
        logic              extent_found;
    } out_item_t;

    function automatic int addr_width(input int pages);
        return (pages > 1) ? $clog2(pages) : 1;
    endfunction

    function automatic int count_width(input int samples);
        return $clog2(samples + 1);
    endfunction

    // one fnv-1a step: xor the byte in, multiply by 2^40 + 0x1b3
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ HASH_W'(b);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v < TICK_MAX) ? v + TICK_W'(1) : TICK_MAX;
    endfunction

endpackage

@@ sv/pccm_page_table.sv @@
module pccm_page_table #(
    parameter int WINDOW_PAGES     = pccm_pkg::WINDOW_PAGES_DEF,
    parameter int SAMPLES_PER_PAGE = pccm_pkg::SAMPLES_PER_PAGE_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               clear_start,
    output logic                                               clearing,
    input  logic                                               rd_en,
    input  logic [pccm_pkg::addr_width(WINDOW_PAGES)-1:0]      rd_addr,
    output logic                                               rd_seen,
    output logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] rd_count,
    output logic [pccm_pkg::HASH_W-1:0]                        rd_hash,
    input  logic                                               wr_en,
    input  logic [pccm_pkg::addr_width(WINDOW_PAGES)-1:0]      wr_addr,
    input  logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] wr_count,
    input  logic [pccm_pkg::HASH_W-1:0]                        wr_hash
);
    import pccm_pkg::*;

    localparam int ADDR_W = addr_width(WINDOW_PAGES);
    localparam int NZ_W   = count_width(SAMPLES_PER_PAGE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_PAGES - 1);

    logic              seen_mem [WINDOW_PAGES];
    logic [NZ_W+HASH_W-1:0] data_mem [WINDOW_PAGES];

    logic              clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic              rd_seen_reg;
    logic [NZ_W-1:0]   rd_count_reg;
    logic [HASH_W-1:0] rd_hash_reg;

    // sweep of the seen bits, one entry a cycle
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_start)
        begin
            clear_active_next = 1'b1;
            clear_addr_next   = '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_active_next = 1'b0;
                clear_addr_next   = '0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_active_reg)
        begin
            seen_mem[clear_addr_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            seen_mem[wr_addr] <= 1'b1;
        end
        if (rd_en)
        begin
            rd_seen_reg <= seen_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[wr_addr] <= {wr_count, wr_hash};
        end
        if (rd_en)
        begin
            {rd_count_reg, rd_hash_reg} <= data_mem[rd_addr];
        end
    end

    assign clearing = clear_active_reg;
    assign rd_seen  = rd_seen_reg;
    assign rd_count = rd_count_reg;
    assign rd_hash  = rd_hash_reg;

endmodule

@@ sv/pccm_sample_stage.sv @@
module pccm_sample_stage #(
    parameter int WINDOW_PAGES     = pccm_pkg::WINDOW_PAGES_DEF,
    parameter int SAMPLES_PER_PAGE = pccm_pkg::SAMPLES_PER_PAGE_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  pccm_pkg::in_item_t                                 in_item,
    input  logic                                               in_accept,
    output logic                                               s1_ready,
    output logic                                               rd_en,
    output logic [pccm_pkg::addr_width(WINDOW_PAGES)-1:0]      rd_addr,
    input  logic                                               rd_seen,
    input  logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] rd_count,
    input  logic [pccm_pkg::HASH_W-1:0]                        rd_hash,
    output logic                                               wr_en,
    output logic [pccm_pkg::addr_width(WINDOW_PAGES)-1:0]      wr_addr,
    output logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] wr_count,
    output logic [pccm_pkg::HASH_W-1:0]                        wr_hash,
    output logic                                               s2_load,
    input  logic                                               s2_ready,
    output pccm_pkg::req_t                                     s2_req,
    output logic [pccm_pkg::IDX_W-1:0]                         s2_idx,
    output logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] s2_nz,
    output logic [pccm_pkg::HASH_W-1:0]                        s2_hash,
    output logic                                               s2_seen,
    output logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] s2_old_count,
    output logic [pccm_pkg::HASH_W-1:0]                        s2_old_hash
);
    import pccm_pkg::*;

    localparam int ADDR_W    = addr_width(WINDOW_PAGES);
    localparam int NZ_W      = count_width(SAMPLES_PER_PAGE);
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int RANGE_W   = ($clog2(WINDOW_PAGES + 1) > IDX_W + 1) ?
                               $clog2(WINDOW_PAGES + 1) : IDX_W + 1;
    localparam logic [NZ_W-1:0] NZ_SAT = NZ_W'(SAMPLES_PER_PAGE);

    logic              s1_valid_reg, s1_valid_next;
    in_item_t          s1_item_reg;
    logic              hit_reg;
    logic [NZ_W-1:0]   fwd_count_reg;
    logic [HASH_W-1:0] fwd_hash_reg;
    logic [HASH_W-1:0] run_hash_reg;
    logic [NZ_W-1:0]   run_nz_reg;

    logic                 in_is_sample, in_range, in_keep;
    logic [IDX_EXT_W-1:0] in_idx_ext, s1_idx_ext;
    logic                 s1_is_sample, s1_closes, s1_to_s2, s1_fire;
    logic [HASH_W-1:0]    hash_new;
    logic [NZ_W-1:0]      nz_new;

    assign in_is_sample = (in_item.req_type == REQ_SAMPLE);
    assign in_range     = (RANGE_W'(in_item.page_index) < RANGE_W'(WINDOW_PAGES));
    // out-of-window samples and unknown requests never enter the pipe
    assign in_keep      = in_is_sample ? in_range :
                          ((in_item.req_type == REQ_UNMAPPED) ||
                           (in_item.req_type == REQ_TICK));
    assign in_idx_ext   = IDX_EXT_W'(in_item.page_index);
    assign s1_idx_ext   = IDX_EXT_W'(s1_item_reg.page_index);

    assign s1_is_sample = (s1_item_reg.req_type == REQ_SAMPLE);
    assign s1_closes    = s1_is_sample && s1_item_reg.last_sample;
    assign s1_to_s2     = !s1_is_sample || s1_item_reg.last_sample;
    assign s1_fire      = s1_valid_reg && (!s1_to_s2 || s2_ready);
    assign s1_ready     = !s1_valid_reg || s1_fire;

    assign hash_new = fnv_step(run_hash_reg, s1_item_reg.sample_byte);
    assign nz_new   = ((s1_item_reg.sample_byte != '0) && (run_nz_reg < NZ_SAT)) ?
                      run_nz_reg + NZ_W'(1) : run_nz_reg;

    // table port: read at acceptance, write when a page closes
    assign rd_en    = in_accept && in_is_sample && in_range;
    assign rd_addr  = in_idx_ext[ADDR_W-1:0];
    assign wr_en    = s1_fire && s1_closes;
    assign wr_addr  = s1_idx_ext[ADDR_W-1:0];
    assign wr_count = nz_new;
    assign wr_hash  = hash_new;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = in_keep;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            run_hash_reg <= FNV_BASIS;
            run_nz_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                // same-edge write to the entry being read: take the new data
                hit_reg <= wr_en && (wr_addr == rd_addr);
            end
            if (s1_fire && s1_is_sample)
            begin
                run_hash_reg <= s1_closes ? FNV_BASIS : hash_new;
                run_nz_reg   <= s1_closes ? '0 : nz_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg   <= in_item;
            fwd_count_reg <= wr_count;
            fwd_hash_reg  <= wr_hash;
        end
    end

    assign s2_load      = s1_fire && s1_to_s2;
    assign s2_req       = req_t'(s1_item_reg.req_type);
    assign s2_idx       = s1_item_reg.page_index;
    assign s2_nz        = nz_new;
    assign s2_hash      = hash_new;
    assign s2_seen      = hit_reg ? 1'b1 : rd_seen;
    assign s2_old_count = hit_reg ? fwd_count_reg : rd_count;
    assign s2_old_hash  = hit_reg ? fwd_hash_reg : rd_hash;

endmodule

@@ sv/pccm_classify.sv @@
module pccm_classify #(
    parameter int SAMPLES_PER_PAGE = pccm_pkg::SAMPLES_PER_PAGE_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic [pccm_pkg::DROP_W-1:0]                        drop_percent,
    input  logic [pccm_pkg::PAGE_W-1:0]                        window_base_page,
    input  logic                                               s2_load,
    output logic                                               s2_ready,
    input  pccm_pkg::req_t                                     s2_req,
    input  logic [pccm_pkg::IDX_W-1:0]                         s2_idx,
    input  logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] s2_nz,
    input  logic [pccm_pkg::HASH_W-1:0]                        s2_hash,
    input  logic                                               s2_seen,
    input  logic [pccm_pkg::count_width(SAMPLES_PER_PAGE)-1:0] s2_old_count,
    input  logic [pccm_pkg::HASH_W-1:0]                        s2_old_hash,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output pccm_pkg::out_item_t                                out_item
);
    import pccm_pkg::*;

    localparam int NZ_W     = count_width(SAMPLES_PER_PAGE);
    localparam int PROD_W   = NZ_W + DROP_W;
    localparam int FULL_MIN = (SAMPLES_PER_PAGE * FULL_PERCENT + PERCENT_SCALE - 1) /
                              PERCENT_SCALE;

    logic              s2_valid_reg, s2_valid_next;
    req_t              s2_req_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [NZ_W-1:0]   s2_nz_reg;
    logic [HASH_W-1:0] s2_hash_reg;
    logic              s2_seen_reg;
    logic [NZ_W-1:0]   s2_old_count_reg;
    logic [HASH_W-1:0] s2_old_hash_reg;

    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    logic [TICK_W-1:0] full_reg, full_next;
    logic [TICK_W-1:0] partial_reg, partial_next;
    logic [TICK_W-1:0] empty_reg, empty_next;
    logic [TICK_W-1:0] unmapped_reg, unmapped_next;
    logic [IDX_W-1:0]  low_reg, low_next;
    logic [IDX_W-1:0]  high_reg, high_next;
    logic              any_reg, any_next;

    logic              has_result, out_can_load, s2_fire;
    page_class_t       page_cls;
    page_event_t       page_ev;
    logic [DROP_W-1:0] pct;
    logic [PROD_W-1:0] drop_lhs, drop_rhs;
    logic              degraded;

    assign has_result   = (s2_req_reg == REQ_SAMPLE) || (s2_req_reg == REQ_TICK);
    assign out_can_load = !out_valid_reg || out_ready;
    assign s2_fire      = s2_valid_reg && (!has_result || out_can_load);
    assign s2_ready     = !s2_valid_reg || s2_fire;

    // degrade test: (old - new) * 100 >= old * pct, pct capped at 100
    assign pct      = (drop_percent > PCT_MAX) ? PCT_MAX : drop_percent;
    assign drop_lhs = PROD_W'(s2_old_count_reg - s2_nz_reg) * PROD_W'(PCT_MAX);
    assign drop_rhs = PROD_W'(s2_old_count_reg) * PROD_W'(pct);
    assign degraded = (s2_nz_reg < s2_old_count_reg) && (drop_lhs >= drop_rhs);

    always_comb
    begin
        if (s2_nz_reg == '0)
        begin
            page_cls = CLS_EMPTY;
        end
        else if (s2_nz_reg >= NZ_W'(FULL_MIN))
        begin
            page_cls = CLS_FULL;
        end
        else
        begin
            page_cls = CLS_PARTIAL;
        end
    end

    always_comb
    begin
        priority if (!s2_seen_reg)
        begin
            page_ev = EV_BASELINE;
        end
        else if ((s2_nz_reg == s2_old_count_reg) && (s2_hash_reg == s2_old_hash_reg))
        begin
            page_ev = EV_UNCHANGED;
        end
        else if (degraded)
        begin
            page_ev = EV_DEGRADED;
        end
        else if (s2_nz_reg == s2_old_count_reg)
        begin
            page_ev = EV_REPLACED;
        end
        else if (s2_nz_reg > s2_old_count_reg)
        begin
            page_ev = EV_FILLED;
        end
        else
        begin
            page_ev = EV_MINOR_DROP;
        end
    end

    always_comb
    begin
        full_next     = full_reg;
        partial_next  = partial_reg;
        empty_next    = empty_reg;
        unmapped_next = unmapped_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        any_next      = any_reg;
        out_item_next = '0;

        unique case (s2_req_reg)
            REQ_SAMPLE:
            begin
                if (page_cls == CLS_EMPTY)
                begin
                    empty_next = sat_inc(empty_reg);
                end
                else
                begin
                    if (!any_reg || (s2_idx_reg < low_reg))
                    begin
                        low_next = s2_idx_reg;
                    end
                    if (!any_reg || (s2_idx_reg > high_reg))
                    begin
                        high_next = s2_idx_reg;
                    end
                    any_next = 1'b1;
                    if (page_cls == CLS_FULL)
                    begin
                        full_next = sat_inc(full_reg);
                    end
                    else
                    begin
                        partial_next = sat_inc(partial_reg);
                    end
                end
                out_item_next.result_kind       = RK_PAGE;
                out_item_next.page_number       = window_base_page + PAGE_W'(s2_idx_reg);
                out_item_next.page_event        = page_ev;
                out_item_next.page_class        = page_cls;
                out_item_next.populated_samples = POP_W'(s2_nz_reg);
            end
            REQ_UNMAPPED:
            begin
                unmapped_next = sat_inc(unmapped_reg);
            end
            REQ_TICK:
            begin
                out_item_next.result_kind    = RK_TICK;
                out_item_next.full_pages     = full_reg;
                out_item_next.partial_pages  = partial_reg;
                out_item_next.empty_pages    = empty_reg;
                out_item_next.unmapped_pages = unmapped_reg;
                if (any_reg)
                begin
                    out_item_next.first_populated = window_base_page + PAGE_W'(low_reg);
                    out_item_next.last_populated  = window_base_page + PAGE_W'(high_reg);
                    out_item_next.extent_found    = 1'b1;
                end
                full_next     = '0;
                partial_next  = '0;
                empty_next    = '0;
                unmapped_next = '0;
                low_next      = '0;
                high_next     = '0;
                any_next      = 1'b0;
            end
            default:
            begin
                out_item_next = '0;
            end
        endcase
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s2_fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            full_reg      <= '0;
            partial_reg   <= '0;
            empty_reg     <= '0;
            unmapped_reg  <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_fire)
            begin
                full_reg     <= full_next;
                partial_reg  <= partial_next;
                empty_reg    <= empty_next;
                unmapped_reg <= unmapped_next;
                low_reg      <= low_next;
                high_reg     <= high_next;
                any_reg      <= any_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_req_reg       <= s2_req;
            s2_idx_reg       <= s2_idx;
            s2_nz_reg        <= s2_nz;
            s2_hash_reg      <= s2_hash;
            s2_seen_reg      <= s2_seen;
            s2_old_count_reg <= s2_old_count;
            s2_old_hash_reg  <= s2_old_hash;
        end
        if (s2_fire && has_result)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ sv/page_content_change_monitor_core.sv @@
// page content change monitor: takes one transaction a cycle while in_ready is high,
// each a sampled byte of a page, an unmapped-page notice or an end-of-tick marker.
// sampled bytes fold into one running 64-bit fnv-1a hash and a nonzero count; the byte
// marked last closes the page named by its index, which is classified (empty, partial,
// full at 90 percent or more), compared with its stored count and hash and reported as
// baseline, unchanged, degraded, replaced, filled or minor drop. an end-of-tick
// transaction returns the tick totals and the populated extent, then clears them.
// sustained rate is one transaction per cycle without back-pressure, set by the running
// hash, which takes one fnv step per cycle; a result passes the sample, classify and
// output registers, and the output register lets new transactions in while a result
// waits. after reset and after every write of the window base register, a clearing pass
// over WINDOW_PAGES entries (65536 by default) sweeps the seen bits of the page table
// with in_ready held low; configuration writes are taken at any time the block is idle
module page_content_change_monitor_core #(
    parameter int WINDOW_PAGES     = pccm_pkg::WINDOW_PAGES_DEF,
    parameter int SAMPLES_PER_PAGE = pccm_pkg::SAMPLES_PER_PAGE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pccm_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pccm_pkg::out_item_t              out_item,
    input  logic                             cfg_we,
    input  logic [pccm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pccm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pccm_pkg::*;

    localparam int ADDR_W = addr_width(WINDOW_PAGES);
    localparam int NZ_W   = count_width(SAMPLES_PER_PAGE);

    // configuration registers
    logic [DROP_W-1:0] drop_percent_reg;
    logic [PAGE_W-1:0] window_base_reg;
    logic              base_write;

    // page table port
    logic              table_clearing;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_seen;
    logic [NZ_W-1:0]   rd_count;
    logic [HASH_W-1:0] rd_hash;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [NZ_W-1:0]   wr_count;
    logic [HASH_W-1:0] wr_hash;

    // sample stage to classify stage
    logic              s1_ready;
    logic              in_accept;
    logic              s2_load;
    logic              s2_ready;
    req_t              s2_req;
    logic [IDX_W-1:0]  s2_idx;
    logic [NZ_W-1:0]   s2_nz;
    logic [HASH_W-1:0] s2_hash;
    logic              s2_seen;
    logic [NZ_W-1:0]   s2_old_count;
    logic [HASH_W-1:0] s2_old_hash;

    // a base write restarts the seen-bit sweep; the running hash and tick totals stay
    assign base_write = cfg_we && (cfg_index == CFG_WINDOW_BASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_percent_reg <= DROP_PERCENT_RST;
            window_base_reg  <= WINDOW_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DROP_PERCENT: drop_percent_reg <= cfg_data[DROP_W-1:0];
                CFG_WINDOW_BASE:  window_base_reg  <= cfg_data[PAGE_W-1:0];
                default:          drop_percent_reg <= drop_percent_reg;
            endcase
        end
    end

    // no transaction enters while the seen bits are being swept
    assign in_ready  = s1_ready && !table_clearing;
    assign in_accept = in_valid && in_ready;

    pccm_page_table #(
        .WINDOW_PAGES     (WINDOW_PAGES),
        .SAMPLES_PER_PAGE (SAMPLES_PER_PAGE)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (base_write),
        .clearing    (table_clearing),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_seen     (rd_seen),
        .rd_count    (rd_count),
        .rd_hash     (rd_hash),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_count    (wr_count),
        .wr_hash     (wr_hash)
    );

    // first stage: running hash and count, stored-entry fetch with same-edge forwarding
    pccm_sample_stage #(
        .WINDOW_PAGES     (WINDOW_PAGES),
        .SAMPLES_PER_PAGE (SAMPLES_PER_PAGE)
    ) u_sample (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_item),
        .in_accept    (in_accept),
        .s1_ready     (s1_ready),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_seen      (rd_seen),
        .rd_count     (rd_count),
        .rd_hash      (rd_hash),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_count     (wr_count),
        .wr_hash      (wr_hash),
        .s2_load      (s2_load),
        .s2_ready     (s2_ready),
        .s2_req       (s2_req),
        .s2_idx       (s2_idx),
        .s2_nz        (s2_nz),
        .s2_hash      (s2_hash),
        .s2_seen      (s2_seen),
        .s2_old_count (s2_old_count),
        .s2_old_hash  (s2_old_hash)
    );

    // second stage: class, event, tick totals and the output register
    pccm_classify #(
        .SAMPLES_PER_PAGE (SAMPLES_PER_PAGE)
    ) u_classify (
        .clk              (clk),
        .rst_n            (rst_n),
        .drop_percent     (drop_percent_reg),
        .window_base_page (window_base_reg),
        .s2_load          (s2_load),
        .s2_ready         (s2_ready),
        .s2_req           (s2_req),
        .s2_idx           (s2_idx),
        .s2_nz            (s2_nz),
        .s2_hash          (s2_hash),
        .s2_seen          (s2_seen),
        .s2_old_count     (s2_old_count),
        .s2_old_hash      (s2_old_hash),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_item         (out_item)
    );

`ifndef ASSERT_OFF
    // the sweep owns the table, so nothing may be accepted during it
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        table_clearing |-> !in_ready
    ) else $error("transaction accepted during clearing pass");

    // a base write always starts a sweep
    a_base_write_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == CFG_WINDOW_BASE)) |=> table_clearing
    ) else $error("window base write did not start clearing pass");

    // an empty page can never have grown
    a_empty_not_filled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.result_kind == RK_PAGE) &&
         (out_item.page_class == CLS_EMPTY)) |-> (out_item.page_event != EV_FILLED)
    ) else $error("empty page reported as filled");

    // no extent means a zero extent
    a_no_extent_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.result_kind == RK_TICK) && !out_item.extent_found) |->
        ((out_item.first_populated == '0) && (out_item.last_populated == '0))
    ) else $error("tick summary without extent carries extent pages");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pccm_pkg::*;

    // geometry and arithmetic of the block as built here
    localparam int          WINDOW      = 65536;
    localparam int          SAMPLES     = 512;
    localparam int          FULL_PCT    = 90;
    localparam int          PCT_CAP     = 100;
    localparam logic [63:0] HASH_SEED   = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] HASH_PRIME  = 64'h0000_0100_0000_01B3;

    // request code the block must ignore
    localparam logic [1:0]  REQ_RESERVED = 2'd3;

    localparam int POOL          = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PCT      = 8;
    localparam int BURST_LEN     = 131075;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block ports; the inputs are driven to known values from time zero
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    page_content_change_monitor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    in_item_t  pending_items [$];     // transactions waiting for the driver
    out_item_t expected_results [$];  // predicted results, oldest first
    int        pushed_count   = 0;
    int        accepted_count = 0;
    int        items_sent     = 0;    // counts everything the block acts on
    int        mismatches     = 0;
    int        results_checked = 0;
    int        event_hits [6];
    int        class_hits [3];
    int        tick_reports = 0;

    // idling controls, switched by the stimulus process
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;
    int        rx_hold_ask  = 0;
    int        rx_hold_done = 0;
    int        rx_hold_left = 0;
    logic      in_taken = 1'b0;

    // ------------------------------------------------------------------
    // predictor state: configuration, page table, running values, tick totals
    // ------------------------------------------------------------------
    logic [DROP_W-1:0] drop_setting = DROP_PERCENT_RST;
    logic [PAGE_W-1:0] base_setting = WINDOW_BASE_RST;
    bit                page_seen  [WINDOW];
    bit   [POP_W-1:0]  page_count [WINDOW];
    bit   [63:0]       page_hash  [WINDOW];
    logic [63:0]       running_hash    = HASH_SEED;
    logic [POP_W-1:0]  running_nonzero = '0;
    logic [TICK_W-1:0] tick_full     = '0;
    logic [TICK_W-1:0] tick_partial  = '0;
    logic [TICK_W-1:0] tick_empty    = '0;
    logic [TICK_W-1:0] tick_unmapped = '0;
    logic [IDX_W-1:0]  low_idx  = '0;
    logic [IDX_W-1:0]  high_idx = '0;
    bit                any_populated = 1'b0;

    // tick counters stick at their top value
    function automatic logic [TICK_W-1:0] count_up(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic apply_register_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_DROP_PERCENT)
        begin
            drop_setting = val[DROP_W-1:0];
        end
        else
        begin
            // new window: every page starts again from a baseline
            base_setting = val[PAGE_W-1:0];
            for (int p = 0; p < WINDOW; p++)
                page_seen[p] = 1'b0;
        end
    endtask

    // works out what one accepted transaction produces, if anything
    task automatic predict_page_events(input in_item_t t);
        out_item_t        r;
        logic [POP_W-1:0] nz;
        logic [POP_W-1:0] old;
        logic [63:0]      h;
        page_event_t      ev;
        page_class_t      cls;
        int               pct;
        r = '0;
        case (t.req_type)
            REQ_SAMPLE:
            begin
                running_hash = (running_hash ^ 64'(t.sample_byte)) * HASH_PRIME;
                if (t.sample_byte != 8'd0 && running_nonzero < POP_W'(SAMPLES))
                    running_nonzero = running_nonzero + 1'b1;
                if (t.last_sample)
                begin
                    nz              = running_nonzero;
                    h               = running_hash;
                    running_nonzero = '0;
                    running_hash    = HASH_SEED;
                    if (nz == '0)
                    begin
                        cls        = CLS_EMPTY;
                        tick_empty = count_up(tick_empty);
                    end
                    else
                    begin
                        if (!any_populated || t.page_index < low_idx)
                            low_idx = t.page_index;
                        if (!any_populated || t.page_index > high_idx)
                            high_idx = t.page_index;
                        any_populated = 1'b1;
                        if (int'(nz) * PCT_CAP >= SAMPLES * FULL_PCT)
                        begin
                            cls       = CLS_FULL;
                            tick_full = count_up(tick_full);
                        end
                        else
                        begin
                            cls          = CLS_PARTIAL;
                            tick_partial = count_up(tick_partial);
                        end
                    end
                    // compare with what the page held at its last close
                    if (!page_seen[t.page_index])
                    begin
                        ev = EV_BASELINE;
                    end
                    else
                    begin
                        old = page_count[t.page_index];
                        pct = (drop_setting > PCT_CAP) ? PCT_CAP : int'(drop_setting);
                        if (nz == old && h == page_hash[t.page_index])
                            ev = EV_UNCHANGED;
                        else if (nz < old && int'(old - nz) * PCT_CAP >= int'(old) * pct)
                            ev = EV_DEGRADED;
                        else if (nz == old)
                            ev = EV_REPLACED;
                        else if (nz > old)
                            ev = EV_FILLED;
                        else
                            ev = EV_MINOR_DROP;
                    end
                    page_seen[t.page_index]  = 1'b1;
                    page_count[t.page_index] = nz;
                    page_hash[t.page_index]  = h;

                    r.result_kind       = RK_PAGE;
                    r.page_number       = base_setting + PAGE_W'(t.page_index);
                    r.page_event        = ev;
                    r.page_class        = cls;
                    r.populated_samples = nz;
                    expected_results.push_back(r);
                    event_hits[int'(ev)]++;
                    class_hits[int'(cls)]++;
                end
            end
            REQ_UNMAPPED:
            begin
                tick_unmapped = count_up(tick_unmapped);
            end
            REQ_TICK:
            begin
                r.result_kind    = RK_TICK;
                r.full_pages     = tick_full;
                r.partial_pages  = tick_partial;
                r.empty_pages    = tick_empty;
                r.unmapped_pages = tick_unmapped;
                if (any_populated)
                begin
                    // extent is kept as indices and placed against the current base
                    r.first_populated = base_setting + PAGE_W'(low_idx);
                    r.last_populated  = base_setting + PAGE_W'(high_idx);
                    r.extent_found    = 1'b1;
                end
                expected_results.push_back(r);
                tick_reports++;
                tick_full     = '0;
                tick_partial  = '0;
                tick_empty    = '0;
                tick_unmapped = '0;
                low_idx       = '0;
                high_idx      = '0;
                any_populated = 1'b0;
            end
            default:
            begin
                // reserved request code, nothing happens
            end
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want !== got)
            note_mismatch($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result, kind %0d page 0x%0h",
                                    got.result_kind, got.page_number));
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("result_kind",       want.result_kind,       got.result_kind);
            compare_field("page_number",       want.page_number,       got.page_number);
            compare_field("page_event",        want.page_event,        got.page_event);
            compare_field("page_class",        want.page_class,        got.page_class);
            compare_field("populated_samples", want.populated_samples, got.populated_samples);
            compare_field("full_pages",        want.full_pages,        got.full_pages);
            compare_field("partial_pages",     want.partial_pages,     got.partial_pages);
            compare_field("empty_pages",       want.empty_pages,       got.empty_pages);
            compare_field("unmapped_pages",    want.unmapped_pages,    got.unmapped_pages);
            compare_field("first_populated",   want.first_populated,   got.first_populated);
            compare_field("last_populated",    want.last_populated,    got.last_populated);
            compare_field("extent_found",      want.extent_found,      got.extent_found);
        end
    endtask

    // ------------------------------------------------------------------
    // rising edge: register writes, accepted transactions, delivered results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                apply_register_write(cfg_index, cfg_data);
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                accepted_count++;
                predict_page_events(in_item);
            end
            if (out_valid && out_ready)
                check_result(out_item);
        end
    end

    // ------------------------------------------------------------------
    // driver: offers the next pending transaction at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a transaction still on offer keeps valid and payload as they are
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 &&
                    !(tx_idle_en && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold when asked for
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready    <= 1'b0;
        end
        else if (rx_hold_ask != rx_hold_done)
        begin
            rx_hold_done <= rx_hold_ask;
            rx_hold_left <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else
        begin
            out_ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] pool_idx [POOL];
    logic [7:0]       pool_data [POOL][$];
    bit               pool_valid [POOL];

    task automatic push_item(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [7:0] b, input logic last);
        in_item_t t;
        t.req_type    = req;
        t.page_index  = idx;
        t.sample_byte = b;
        t.last_sample = last;
        pending_items.push_back(t);
        pushed_count++;
        if (req != REQ_RESERVED)
            items_sent++;
    endtask

    // one page as a run of samples; mixed puts stray indices on all but the last
    task automatic push_page(input logic [IDX_W-1:0] idx, input logic [7:0] bytes [$],
                             input bit mixed);
        int n;
        n = bytes.size();
        for (int i = 0; i < n; i++)
            push_item(REQ_SAMPLE, (mixed && i != n - 1) ? IDX_W'($urandom) : idx,
                      bytes[i], i == n - 1);
    endtask

    function automatic logic [7:0] random_sample();
        return ($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    task automatic reseed_pool();
        pool_idx[0] = '0;
        pool_idx[1] = '1;
        pool_idx[2] = IDX_W'($urandom);
        pool_idx[3] = pool_idx[2] + 1'b1;
        for (int s = 4; s < POOL; s++)
            pool_idx[s] = IDX_W'($urandom);
    endtask

    // revisits a page of the pool with content that is new, the same, or edited
    task automatic random_page(input int slot);
        logic [7:0] bytes [$];
        int         nonzero_at [$];
        int         mode;
        int         pick;
        logic [7:0] v;
        bytes = pool_data[slot];
        mode  = pool_valid[slot] ? $urandom_range(0, 9) : 0;
        if (bytes.size() > 40)
            mode = 0;
        case (mode)
            2, 3:
            begin
                // same content again
            end
            4:
            begin
                // same count, one nonzero byte takes another nonzero value; with none, a nonzero byte is added
                for (int i = 0; i < bytes.size(); i++)
                    if (bytes[i] != 8'h00)
                        nonzero_at.push_back(i);
                if (nonzero_at.size() == 0)
                begin
                    bytes.push_back(8'($urandom_range(1, 255)));
                end
                else
                begin
                    pick = nonzero_at[$urandom_range(0, nonzero_at.size() - 1)];
                    v    = 8'($urandom_range(1, 255));
                    if (v == bytes[pick])
                        v = (v == 8'hFF) ? 8'h01 : v + 8'h01;
                    bytes[pick] = v;
                end
            end
            5, 6:
            begin
                for (int i = 0; i < bytes.size(); i++)
                    if (bytes[i] != 8'h00 && $urandom_range(0, 2) == 0)
                        bytes[i] = 8'h00;
            end
            7:
            begin
                repeat ($urandom_range(1, 3))
                    bytes.push_back(8'($urandom_range(1, 255)));
            end
            8:
            begin
                bytes = {};
                repeat ($urandom_range(1, 6))
                    bytes.push_back(8'h00);
            end
            default:
            begin
                bytes = {};
                repeat ($urandom_range(1, 12))
                    bytes.push_back(random_sample());
            end
        endcase
        push_page(pool_idx[slot], bytes, mode == 9);
        pool_data[slot]  = bytes;
        pool_valid[slot] = 1'b1;
    endtask

    // mostly whole pages, with unmapped notices, ticks, reserved codes and stray samples
    task automatic random_traffic(input int n);
        int stop_at;
        int r;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                random_page($urandom_range(0, POOL - 1));
            else if (r < 80)
                push_item(REQ_UNMAPPED, IDX_W'($urandom), 8'($urandom), 1'($urandom));
            else if (r < 88)
                push_item(REQ_TICK, IDX_W'($urandom), 8'($urandom), 1'($urandom));
            else if (r < 91)
                push_item(REQ_RESERVED, IDX_W'($urandom), 8'($urandom), 1'($urandom));
            else
                push_item(REQ_SAMPLE, IDX_W'($urandom), 8'($urandom), 1'b0);
        end
    endtask

    // sender pause: nothing on offer and nothing outstanding, then a short settle
    task automatic drain_and_settle();
        while (pushed_count != accepted_count || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic directed_checks();
        push_page(16'h0000, '{8'h00}, 1'b0);          // empty page, baseline
        push_page(16'hFFFF, '{8'hFF, 8'h01}, 1'b0);   // top index, partial
        push_page(16'h0000, '{8'hFF}, 1'b0);          // filled
        push_page(16'h0000, '{8'hFF}, 1'b0);          // unchanged
        push_page(16'h0000, '{8'h80}, 1'b0);          // replaced
        push_page(16'hFFFF, '{8'h00, 8'h00}, 1'b0);   // degraded to nothing
        push_item(REQ_UNMAPPED, 16'h1234, 8'h00, 1'b0);
        push_item(REQ_RESERVED, 16'hFFFF, 8'hFF, 1'b1);
        push_item(REQ_TICK, 16'h0000, 8'h00, 1'b0);
        push_page(16'h0007, '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 1'b0);
        push_page(16'h0007, '{8'h11, 8'h22, 8'h33, 8'h44, 8'h00}, 1'b0);  // minor drop
        // running values ignore the index; the closing sample picks the page
        push_item(REQ_SAMPLE, 16'h0003, 8'h05, 1'b0);
        push_item(REQ_SAMPLE, 16'h0009, 8'h00, 1'b1);
        push_item(REQ_TICK, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    // full-page threshold, count saturation, then a total loss
    task automatic long_pages(input logic [IDX_W-1:0] idx);
        logic [7:0] bytes [$];
        repeat (461) bytes.push_back(8'($urandom_range(1, 255)));
        repeat (19) bytes.push_back(8'h00);
        push_page(idx, bytes, 1'b0);
        bytes = {};
        repeat (530) bytes.push_back(8'($urandom_range(1, 255)));
        push_page(idx, bytes, 1'b0);
        push_page(idx, '{8'h00}, 1'b0);
        push_page(idx, '{8'h00}, 1'b0);
        push_item(REQ_TICK, '0, '0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial
    begin
        reseed_pool();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset settings; the block clears its table before taking anything
        directed_checks();
        drain_and_settle();
        random_traffic(300);
        // leave a page open and totals pending across the base write
        push_item(REQ_SAMPLE, IDX_W'($urandom), 8'hA5, 1'b0);
        push_item(REQ_SAMPLE, IDX_W'($urandom), 8'h00, 1'b0);
        push_item(REQ_UNMAPPED, IDX_W'($urandom), 8'h00, 1'b0);
        drain_and_settle();

        // any drop counts as degraded, window at page zero
        write_register(CFG_DROP_PERCENT, CFG_DATA_W'(0));
        write_register(CFG_WINDOW_BASE, CFG_DATA_W'(0));
        reseed_pool();
        random_traffic(150);
        repeat (BURST_LEN) push_item(REQ_UNMAPPED, IDX_W'($urandom), 8'($urandom), 1'b0);
        push_item(REQ_TICK, '0, '0, 1'b0);
        random_traffic(150);
        drain_and_settle();

        // only a total loss degrades; window at the top so page numbers wrap
        write_register(CFG_DROP_PERCENT, CFG_DATA_W'(100));
        write_register(CFG_WINDOW_BASE, {CFG_DATA_W{1'b1}});
        reseed_pool();
        long_pages(16'h8000);
        random_traffic(200);
        drain_and_settle();

        // percent above the scale, random window, no idling on either side
        write_register(CFG_DROP_PERCENT, CFG_DATA_W'(127));
        write_register(CFG_WINDOW_BASE, CFG_DATA_W'($urandom));
        reseed_pool();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_traffic(250);
        drain_and_settle();

        // receiver holds off while the sender keeps offering single-sample pages
        rx_hold_ask++;
        repeat (80) push_page(IDX_W'($urandom), '{8'($urandom)}, 1'b0);
        push_item(REQ_TICK, '0, '0, 1'b0);
        drain_and_settle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // new threshold only; the page table is kept
        write_register(CFG_DROP_PERCENT, CFG_DATA_W'($urandom_range(1, 99)));
        random_traffic(250);
        drain_and_settle();

        $display("run: %0d transactions, %0d results checked, %0d of them tick summaries",
                 items_sent, results_checked, tick_reports);
        $display("events base/same/degr/repl/fill/minor %0d/%0d/%0d/%0d/%0d/%0d, "
                 , event_hits[0], event_hits[1], event_hits[2], event_hits[3],
                 event_hits[4], event_hits[5],
                 "classes empty/partial/full %0d/%0d/%0d",
                 class_hits[0], class_hits[1], class_hits[2]);
        if (mismatches == 0)
        begin
            $display("** page_content_change_monitor_core: PASSED **");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("** page_content_change_monitor_core: FAILED **");
        end
        $finish;
    end

    // watchdog, several times the slowest correct run including the clearing passes
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results still outstanding", expected_results.size());
        $display("** page_content_change_monitor_core: FAILED **");
        $finish;
    end

endmodule
